[rtl/core/rgb_led_frame_pwm_encoder_assert.svh]
// Assertion macros used by the encoder back end.
// RLFE_ASSERT checks a property on every clock edge outside reset.
// RLFE_ASSERT_ALWAYS checks a property on every clock edge, reset included.
`ifndef RGB_LED_FRAME_PWM_ENCODER_ASSERT_SVH
`define RGB_LED_FRAME_PWM_ENCODER_ASSERT_SVH
`ifndef SYNTHESIS
`define RLFE_ASSERT(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) \
    else $error("rlfe assertion failed");
`define RLFE_ASSERT_ALWAYS(lbl, ck, prop) \
  lbl: assert property (@(posedge ck) prop) \
    else $error("rlfe assertion failed");
`else
`define RLFE_ASSERT(lbl, ck, rs, prop)
`define RLFE_ASSERT_ALWAYS(lbl, ck, prop)
`endif
`endif

[rtl/core/rlfe_pkg.sv]
`timescale 1ns / 1ps

package rlfe_pkg;

  // Sizing
  localparam int DEF_MAX_LEDS = 64;
  localparam int QUEUE_DEPTH  = 2;
  localparam int BITS_PER_LED = 24;
  localparam int GAIN_W       = 17;

  // Opcodes of an input word
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_UPDATE = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  // Brightness of 1.0 in Q8
  localparam logic [8:0] LEVEL_FULL = 9'd256;

  // Register reset values
  localparam logic [6:0]  RST_LED_COUNT    = 7'd64;
  localparam logic [7:0]  RST_RESET_WORDS  = 8'd48;
  localparam logic [15:0] RST_DUTY         = 16'd0;
  localparam logic [8:0]  RST_GLOBAL_LEVEL = 9'd256;

  typedef enum logic [2:0] {
    REG_LED_COUNT,
    REG_RESET_WORDS,
    REG_DUTY_ONE,
    REG_DUTY_ZERO,
    REG_DUTY_RESET,
    REG_GLOBAL_LEVEL
  } reg_index_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] pixel;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [8:0] level;
  } item_t;

  typedef struct packed {
    logic [15:0] duty_word;
    logic        frame_end;
  } result_t;

  typedef struct packed {
    logic [6:0]  chain_leds;
    logic [7:0]  reset_words;
    logic [15:0] duty_one;
    logic [15:0] duty_zero;
    logic [15:0] duty_latch;
    logic [8:0]  global_level;
  } cfg_t;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_UPDATE,
    CMD_TICK
  } cmd_kind_t;

  // Classified command passed from front to back
  typedef struct packed {
    cmd_kind_t         kind;
    logic [7:0]        pixel;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [GAIN_W-1:0] gain;
  } cmd_t;

endpackage

[rtl/core/rlfe_ram.sv]
`timescale 1ns / 1ps

module rlfe_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/rlfe_queue.sv]
`timescale 1ns / 1ps

module rlfe_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rlfe_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output rlfe_pkg::cmd_t head_cmd
);

  import rlfe_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = slots[rptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Hold commands in order, advance pointers on push and pop
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        slots[wptr] <= push_cmd;
        wptr <= (wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/core/rlfe_front.sv]
`timescale 1ns / 1ps

module rlfe_front #(
  parameter int MAX_LEDS = rlfe_pkg::DEF_MAX_LEDS
) (
  input  logic            item_valid,
  output logic            item_ready,
  input  rlfe_pkg::item_t item,
  input  rlfe_pkg::cfg_t  cfg,
  input  logic            q_full,
  output logic            q_push,
  output rlfe_pkg::cmd_t  q_cmd
);

  import rlfe_pkg::*;

  localparam int ACT_W = $clog2(MAX_LEDS + 1);

  logic [ACT_W-1:0] act_leds;
  logic [8:0]       lvl_c;
  logic [8:0]       glob_c;
  logic [17:0]      gain_full;
  logic             keep;

  // Clamp the LED count to the store depth
  assign act_leds = (32'(cfg.chain_leds) > 32'(MAX_LEDS)) ? ACT_W'(MAX_LEDS)
                                                          : ACT_W'(cfg.chain_leds);

  // Combined brightness, both Q8 clamped to 1.0
  assign lvl_c     = (item.level > LEVEL_FULL) ? LEVEL_FULL : item.level;
  assign glob_c    = (cfg.global_level > LEVEL_FULL) ? LEVEL_FULL : cfg.global_level;
  assign gain_full = 18'(lvl_c) * 18'(glob_c);

  // Classify: drop writes out of range, empty frames and unused opcodes
  always_comb begin
    keep       = 1'b0;
    q_cmd.kind = CMD_TICK;
    case (item.opcode)
      OP_WRITE: begin
        q_cmd.kind = CMD_WRITE;
        keep       = (32'(item.pixel) < 32'(act_leds));
      end
      OP_UPDATE: begin
        q_cmd.kind = CMD_UPDATE;
        keep       = (act_leds != '0) || (cfg.reset_words != '0);
      end
      OP_TICK: begin
        q_cmd.kind = CMD_TICK;
        keep       = 1'b1;
      end
      default: keep = 1'b0;
    endcase
    q_cmd.pixel = item.pixel;
    q_cmd.red   = item.red;
    q_cmd.green = item.green;
    q_cmd.blue  = item.blue;
    q_cmd.gain  = gain_full[GAIN_W-1:0];
  end

  assign item_ready = !q_full;
  assign q_push     = item_valid && item_ready && keep;

endmodule

[rtl/core/rlfe_back.sv]
`timescale 1ns / 1ps
`include "rgb_led_frame_pwm_encoder_assert.svh"

module rlfe_back #(
  parameter int MAX_LEDS = rlfe_pkg::DEF_MAX_LEDS
) (
  input  logic              clk,
  input  logic              rst,
  input  rlfe_pkg::cfg_t    cfg,
  input  logic              q_valid,
  input  rlfe_pkg::cmd_t    q_cmd,
  output logic              q_pop,
  output logic              result_valid,
  input  logic              result_ready,
  output rlfe_pkg::result_t result
);

  import rlfe_pkg::*;

  localparam int ADDR_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int ACT_W  = $clog2(MAX_LEDS + 1);
  localparam int POS_W  = $clog2(MAX_LEDS * BITS_PER_LED + 256);
  localparam int LCNT_W = $clog2((MAX_LEDS * BITS_PER_LED + 256) / BITS_PER_LED + 1);
  localparam logic [4:0] BIT_TOP = 5'(BITS_PER_LED - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCALE,
    S_COPY,
    S_TICK
  } state_t;

  state_t              state;
  cmd_t                wr_cmd;
  logic                sending;
  logic [POS_W-1:0]    pos;
  logic [LCNT_W-1:0]   led_idx;
  logic [4:0]          bit_idx;
  logic [ADDR_W:0]     copy_rd;
  logic                cp_we;
  logic [ADDR_W-1:0]   cp_addr;

  logic [ACT_W-1:0]    act_leds;
  logic [POS_W-1:0]    frame_len;
  logic [POS_W:0]      pos_inc;
  logic                tick_last;
  logic                in_leds;
  logic                load_out;
  result_t             tick_result;

  logic [24:0]         prod_r;
  logic [24:0]         prod_g;
  logic [24:0]         prod_b;
  logic [23:0]         scaled;
  logic [ADDR_W-1:0]   wr_addr;
  logic                store_we;
  logic [ADDR_W-1:0]   store_waddr;
  logic [23:0]         store_wdata;
  logic [23:0]         store_rdata;
  logic [23:0]         snap_rdata;

  // Live frame geometry from the registers
  assign act_leds  = (32'(cfg.chain_leds) > 32'(MAX_LEDS)) ? ACT_W'(MAX_LEDS)
                                                           : ACT_W'(cfg.chain_leds);
  assign frame_len = POS_W'({act_leds, 4'b0}) + POS_W'({act_leds, 3'b0})
                   + POS_W'(cfg.reset_words);
  assign pos_inc   = {1'b0, pos} + (POS_W + 1)'(1);
  assign tick_last = (pos_inc >= {1'b0, frame_len});
  assign in_leds   = (32'(led_idx) < 32'(act_leds));

  // Pick the duty word for the current bit period
  always_comb begin
    if (in_leds) begin
      tick_result.duty_word = snap_rdata[bit_idx] ? cfg.duty_one : cfg.duty_zero;
    end else begin
      tick_result.duty_word = cfg.duty_latch;
    end
    tick_result.frame_end = tick_last;
  end

  assign load_out = (state == S_TICK) && (!result_valid || result_ready);
  assign q_pop    = (state == S_IDLE) && q_valid;

  // Scale each channel by the combined brightness, keep the integer part
  assign prod_r  = 25'(wr_cmd.red) * 25'(wr_cmd.gain);
  assign prod_g  = 25'(wr_cmd.green) * 25'(wr_cmd.gain);
  assign prod_b  = 25'(wr_cmd.blue) * 25'(wr_cmd.gain);
  assign scaled  = {prod_g[23:16], prod_r[23:16], prod_b[23:16]};
  assign wr_addr = ADDR_W'(wr_cmd.pixel);

  // Zero the store during the clearing pass, else write the scaled colour
  assign store_we    = (state == S_SCALE) || (state == S_CLEAR);
  assign store_waddr = (state == S_CLEAR) ? copy_rd[ADDR_W-1:0] : wr_addr;
  assign store_wdata = (state == S_CLEAR) ? '0 : scaled;

  rlfe_ram #(
    .WIDTH(24),
    .DEPTH(MAX_LEDS)
  ) u_store (
    .clk  (clk),
    .we   (store_we),
    .waddr(store_waddr),
    .wdata(store_wdata),
    .raddr(copy_rd[ADDR_W-1:0]),
    .rdata(store_rdata)
  );

  rlfe_ram #(
    .WIDTH(24),
    .DEPTH(MAX_LEDS)
  ) u_snap (
    .clk  (clk),
    .we   (cp_we),
    .waddr(cp_addr),
    .wdata(store_rdata),
    .raddr(led_idx[ADDR_W-1:0]),
    .rdata(snap_rdata)
  );

  // Sequencer: clear the store once, then execute one command at a time
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      sending      <= 1'b0;
      pos          <= '0;
      led_idx      <= '0;
      bit_idx      <= BIT_TOP;
      copy_rd      <= '0;
      cp_we        <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready && !load_out) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          // Walk every store address once, the copy counter serves as address
          if (copy_rd == (ADDR_W + 1)'(MAX_LEDS - 1)) begin
            state <= S_IDLE;
          end else begin
            copy_rd <= copy_rd + 1'b1;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            case (q_cmd.kind)
              CMD_WRITE: begin
                wr_cmd <= q_cmd;
                state  <= S_SCALE;
              end
              CMD_UPDATE: begin
                if (!sending) begin
                  copy_rd <= '0;
                  state   <= S_COPY;
                end
              end
              CMD_TICK: begin
                if (sending) begin
                  state <= S_TICK;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_SCALE: begin
          state <= S_IDLE;
        end
        S_COPY: begin
          // Stream the store into the snapshot behind its registered read
          if (copy_rd == (ADDR_W + 1)'(MAX_LEDS)) begin
            cp_we   <= 1'b0;
            sending <= 1'b1;
            pos     <= '0;
            led_idx <= '0;
            bit_idx <= BIT_TOP;
            state   <= S_IDLE;
          end else begin
            cp_we   <= 1'b1;
            cp_addr <= copy_rd[ADDR_W-1:0];
            copy_rd <= copy_rd + 1'b1;
          end
        end
        S_TICK: begin
          if (load_out) begin
            result_valid <= 1'b1;
            result       <= tick_result;
            state        <= S_IDLE;
            if (tick_last) begin
              sending <= 1'b0;
              pos     <= '0;
              led_idx <= '0;
              bit_idx <= BIT_TOP;
            end else begin
              pos <= pos_inc[POS_W-1:0];
              if (bit_idx == '0) begin
                bit_idx <= BIT_TOP;
                led_idx <= led_idx + 1'b1;
              end else begin
                bit_idx <= bit_idx - 1'b1;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `RLFE_ASSERT(a_copy_idle_frame, clk, rst, (state == S_COPY) |-> !sending)
  `RLFE_ASSERT(a_word_from_tick, clk, rst, $rose(result_valid) |-> $past(state == S_TICK))
  `RLFE_ASSERT(a_frame_ends_on_last, clk, rst, $fell(sending) |-> $past(load_out && tick_last))
  `RLFE_ASSERT(a_frame_starts_after_copy, clk, rst, $rose(sending) |-> $past(state == S_COPY))
  `RLFE_ASSERT(a_bit_in_range, clk, rst, bit_idx <= BIT_TOP)

endmodule

[rtl/core/rgb_led_frame_pwm_encoder.sv]
`timescale 1ns / 1ps
// Channel   Handshake                  Word
// item      item_valid / item_ready    item   (rlfe_pkg::item_t)
// result    result_valid / result_ready result (rlfe_pkg::result_t)
// cfg       cfg_valid / cfg_ready      cfg_index, cfg_data
//
// A colour write passes through the scaling state of the back end; a tick reads
// the snapshot, then loads the output register; a dropped item never reaches the queue.
// A frame start copies the whole store into the snapshot word by word, through
// the single read port of the colour store.
// Reset is synchronous; a clearing pass then zeroes every colour store address
// while input words wait in the queue.
// A two-word queue parts the front from the back, so items are taken while a
// result waits; the front stalls only when the queue is full.

module rgb_led_frame_pwm_encoder #(
  parameter int MAX_LEDS = rlfe_pkg::DEF_MAX_LEDS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  rlfe_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output rlfe_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data
);

  import rlfe_pkg::*;

  cfg_t cfg;
  logic q_full;
  logic q_push;
  cmd_t push_cmd;
  logic q_pop;
  logic q_valid;
  cmd_t head_cmd;

  assign cfg_ready = 1'b1;

  // Register file, written by index
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.chain_leds   <= RST_LED_COUNT;
      cfg.reset_words  <= RST_RESET_WORDS;
      cfg.duty_one     <= RST_DUTY;
      cfg.duty_zero    <= RST_DUTY;
      cfg.duty_latch   <= RST_DUTY;
      cfg.global_level <= RST_GLOBAL_LEVEL;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LED_COUNT:    cfg.chain_leds   <= cfg_data[6:0];
        REG_RESET_WORDS:  cfg.reset_words  <= cfg_data[7:0];
        REG_DUTY_ONE:     cfg.duty_one     <= cfg_data;
        REG_DUTY_ZERO:    cfg.duty_zero    <= cfg_data;
        REG_DUTY_RESET:   cfg.duty_latch   <= cfg_data;
        REG_GLOBAL_LEVEL: cfg.global_level <= cfg_data[8:0];
        default:          cfg.chain_leds   <= cfg.chain_leds;
      endcase
    end
  end

  rlfe_front #(
    .MAX_LEDS(MAX_LEDS)
  ) u_front (
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item      (item),
    .cfg       (cfg),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  rlfe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_valid),
    .head_cmd  (head_cmd)
  );

  rlfe_back #(
    .MAX_LEDS(MAX_LEDS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_valid     (q_valid),
    .q_cmd       (head_cmd),
    .q_pop       (q_pop),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

endmodule

[tb/duty_word_checker.sv]
`timescale 1ns / 1ps

module duty_word_checker #(
  parameter int MAX_LEDS = rlfe_pkg::DEF_MAX_LEDS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_ready,
  input  rlfe_pkg::item_t   item,
  input  logic              result_valid,
  input  logic              result_ready,
  input  rlfe_pkg::result_t result,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output int                errors,
  output int                pending
);

  import rlfe_pkg::*;

  // Live register copies and the predicted encoder state
  cfg_t        regs;
  logic [23:0] colour_store [MAX_LEDS];
  logic [23:0] frame_copy [MAX_LEDS];
  logic        sending;
  int unsigned word_pos;
  result_t     duty_q [$];
  result_t     want;

  function automatic int unsigned leds_used();
    return (regs.chain_leds > MAX_LEDS) ? MAX_LEDS : regs.chain_leds;
  endfunction

  function automatic int unsigned frame_words();
    return leds_used() * BITS_PER_LED + regs.reset_words;
  endfunction

  // Q8 times Q8 brightness, truncated
  function automatic logic [7:0] scale(logic [7:0] c, int unsigned lvl, int unsigned glob);
    int unsigned prod;
    prod = c * lvl * glob;
    return 8'(prod >> 16);
  endfunction

  // Advance the model by one accepted word; queue a duty word on a live tick
  task automatic encode_item(item_t w);
    int unsigned lvl;
    int unsigned glob;
    int unsigned bit_no;
    logic [23:0] grb;
    result_t     r;
    case (w.opcode)
      OP_WRITE: begin
        if (w.pixel < leds_used()) begin
          lvl  = (w.level > LEVEL_FULL) ? LEVEL_FULL : w.level;
          glob = (regs.global_level > LEVEL_FULL) ? LEVEL_FULL : regs.global_level;
          colour_store[w.pixel] = {scale(w.green, lvl, glob), scale(w.red, lvl, glob),
                                   scale(w.blue, lvl, glob)};
        end
      end
      OP_UPDATE: begin
        if (!sending && frame_words() != 0) begin
          frame_copy = colour_store;
          sending    = 1'b1;
          word_pos   = 0;
        end
      end
      OP_TICK: begin
        if (sending) begin
          if (word_pos < leds_used() * BITS_PER_LED) begin
            grb         = frame_copy[word_pos / BITS_PER_LED];
            bit_no      = BITS_PER_LED - 1 - word_pos % BITS_PER_LED;
            r.duty_word = grb[bit_no] ? regs.duty_one : regs.duty_zero;
          end else begin
            r.duty_word = regs.duty_latch;
          end
          r.frame_end = (word_pos + 1 >= frame_words());
          if (r.frame_end) begin
            sending  = 1'b0;
            word_pos = 0;
          end else begin
            word_pos = word_pos + 1;
          end
          duty_q.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      regs     = '{chain_leds: RST_LED_COUNT, reset_words: RST_RESET_WORDS,
                   duty_one: RST_DUTY, duty_zero: RST_DUTY, duty_latch: RST_DUTY,
                   global_level: RST_GLOBAL_LEVEL};
      foreach (colour_store[i]) colour_store[i] = '0;
      sending  = 1'b0;
      word_pos = 0;
      errors   = 0;
      duty_q.delete();
    end else begin
      // Apply register writes as they land
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LED_COUNT:    regs.chain_leds   = cfg_data[6:0];
          REG_RESET_WORDS:  regs.reset_words  = cfg_data[7:0];
          REG_DUTY_ONE:     regs.duty_one     = cfg_data;
          REG_DUTY_ZERO:    regs.duty_zero    = cfg_data;
          REG_DUTY_RESET:   regs.duty_latch   = cfg_data;
          REG_GLOBAL_LEVEL: regs.global_level = cfg_data[8:0];
          default: ;
        endcase
      end
      // Compare each result word with the oldest expectation
      if (result_valid && result_ready) begin
        if (duty_q.size() == 0) begin
          $error("unexpected result word: duty_word %0d frame_end %0d",
                 result.duty_word, result.frame_end);
          errors++;
        end else begin
          want = duty_q.pop_front();
          if (result.duty_word !== want.duty_word) begin
            $error("duty_word: expected %0d, actual %0d", want.duty_word, result.duty_word);
            errors++;
          end
          if (result.frame_end !== want.frame_end) begin
            $error("frame_end: expected %0d, actual %0d", want.frame_end, result.frame_end);
            errors++;
          end
        end
      end
      if (item_valid && item_ready) encode_item(item);
    end
    pending <= duty_q.size();
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import rlfe_pkg::*;

  localparam logic [1:0] OP_SPARE   = 2'd3;
  localparam int         ITEM_GOAL  = 1750;
  localparam int         SETTLE     = DEF_MAX_LEDS + 16;
  localparam int         CYCLE_CAP  = 600000;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        item_valid   = 1'b0;
  logic        item_ready;
  item_t       item         = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  result_t     result;
  logic        cfg_valid    = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index    = '0;
  logic [15:0] cfg_data     = '0;
  int          errors;
  int          pending;

  // Stimulus-side copy of the registers and of the frame in flight
  cfg_t        regs;
  logic        tx_on;
  int unsigned tx_pos;
  int          n_items;
  bit          steady;
  bit          rx_steady;
  int          rx_stall;
  int          rx_draw;
  int unsigned cycles = 0;

  always #2 clk = ~clk;

  rgb_led_frame_pwm_encoder u_top (
    .clk, .rst, .item_valid, .item_ready, .item, .result_valid, .result_ready,
    .result, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  duty_word_checker u_check (
    .clk, .rst, .item_valid, .item_ready, .item, .result_valid, .result_ready,
    .result, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .errors, .pending
  );

  // Result side: a random stall, possibly none, after each word, with calm stretches now and then
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      rx_stall     <= 0;
      rx_steady    <= 1'b0;
    end else if (result_valid && result_ready) begin
      if ($urandom_range(0, 31) == 0) rx_steady <= ~rx_steady;
      rx_draw = rx_steady ? 0 : $urandom_range(0, 10);
      rx_stall     <= rx_draw;
      result_ready <= (rx_draw == 0);
    end else if (rx_stall != 0) begin
      rx_stall     <= rx_stall - 1;
      result_ready <= (rx_stall == 1);
    end else begin
      result_ready <= 1'b1;
    end
  end

  // Guard against a hang
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_CAP) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int unsigned frame_len();
    int unsigned leds;
    leds = (regs.chain_leds > DEF_MAX_LEDS) ? DEF_MAX_LEDS : regs.chain_leds;
    return leds * BITS_PER_LED + regs.reset_words;
  endfunction

  function automatic logic [8:0] pick_level();
    case ($urandom_range(0, 7))
      0:       return 9'd0;
      1:       return LEVEL_FULL;
      2:       return 9'($urandom_range(257, 511));
      default: return 9'($urandom_range(1, 255));
    endcase
  endfunction

  function automatic logic [15:0] pick_duty();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    return 16'($urandom);
  endfunction

  // Mostly inside the chain, sometimes anywhere in the index range
  function automatic logic [7:0] pick_index();
    int unsigned leds;
    leds = (regs.chain_leds > DEF_MAX_LEDS) ? DEF_MAX_LEDS : regs.chain_leds;
    if (leds == 0 || $urandom_range(0, 4) == 0) return 8'($urandom);
    return 8'($urandom_range(0, leds - 1));
  endfunction

  function automatic item_t any_item(logic [1:0] op);
    item_t w;
    w.opcode = op;
    w.pixel  = 8'($urandom);
    w.red    = 8'($urandom);
    w.green  = 8'($urandom);
    w.blue   = 8'($urandom);
    w.level  = 9'($urandom);
    return w;
  endfunction

  function automatic item_t colour_item(logic [7:0] idx, logic [7:0] r, logic [7:0] g,
                                        logic [7:0] b, logic [8:0] lvl);
    item_t w;
    w       = any_item(OP_WRITE);
    w.pixel = idx;
    w.red   = r;
    w.green = g;
    w.blue  = b;
    w.level = lvl;
    return w;
  endfunction

  // Offer one input word after a random gap and hold it until taken
  task automatic send(item_t w);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item       <= w;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    if (w.opcode == OP_UPDATE && !tx_on && frame_len() != 0) begin
      tx_on  = 1'b1;
      tx_pos = 0;
    end else if (w.opcode == OP_TICK && tx_on) begin
      if (tx_pos + 1 >= frame_len()) tx_on = 1'b0;
      else tx_pos = tx_pos + 1;
    end
    n_items++;
  endtask

  task automatic put(reg_index_t idx, logic [15:0] v);
    cfg_index <= idx;
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Write all six registers, then drop the request
  task automatic load_regs(cfg_t c);
    put(REG_LED_COUNT,    16'(c.chain_leds));
    put(REG_RESET_WORDS,  16'(c.reset_words));
    put(REG_DUTY_ONE,     c.duty_one);
    put(REG_DUTY_ZERO,    c.duty_zero);
    put(REG_DUTY_RESET,   c.duty_latch);
    put(REG_GLOBAL_LEVEL, 16'(c.global_level));
    cfg_valid <= 1'b0;
    regs = c;
  endtask

  // Hold off input until every expected word is back, then let the back end settle
  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // One tick, now and then preceded by a stray word
  task automatic frame_tick();
    if ($urandom_range(0, 11) == 0) begin
      case ($urandom_range(0, 2))
        0:       send(colour_item(pick_index(), 8'($urandom), 8'($urandom), 8'($urandom),
                                  pick_level()));
        1:       send(any_item(OP_UPDATE));
        default: send(any_item(OP_SPARE));
      endcase
    end
    send(any_item(OP_TICK));
  endtask

  // Configure, paint some LEDs, send a frame; long chains are cut short mid-frame
  task automatic run_phase(int phase);
    cfg_t next;
    int   writes;
    int   cut;
    bit   wide;
    drain();
    steady = ($urandom_range(0, 3) == 0);
    wide   = (phase == 1 || phase == 2 || $urandom_range(0, 11) == 0);
    if (phase == 1)      next.chain_leds = 7'd127;
    else if (phase == 2) next.chain_leds = 7'd64;
    else if (wide)       next.chain_leds = 7'($urandom_range(64, 127));
    else                 next.chain_leds = 7'($urandom_range(0, 4));
    if (phase == 0)                      next.reset_words = 8'd255;
    else if ($urandom_range(0, 7) == 0)  next.reset_words = 8'($urandom);
    else                                 next.reset_words = 8'($urandom_range(0, 8));
    next.duty_one   = pick_duty();
    next.duty_zero  = pick_duty();
    next.duty_latch = pick_duty();
    if (phase == 0)      next.global_level = 9'h1FF;
    else if (phase == 1) next.global_level = 9'd0;
    else                 next.global_level = pick_level();
    load_regs(next);
    writes = wide ? $urandom_range(1, 16) : $urandom_range(1, 8);
    repeat (writes) begin
      send(colour_item(pick_index(), 8'($urandom), 8'($urandom), 8'($urandom),
                       pick_level()));
    end
    send(any_item(OP_UPDATE));
    if (wide) begin
      cut = $urandom_range(1, 60);
      while (tx_on && cut > 0) begin
        frame_tick();
        cut--;
      end
      drain();
      next.chain_leds  = 7'($urandom_range(0, 3));
      next.reset_words = 8'($urandom_range(0, 4));
      load_regs(next);
    end
    while (tx_on) frame_tick();
    if ($urandom_range(0, 3) == 0) send(any_item(OP_TICK));
  endtask

  initial begin
    regs    = '{chain_leds: RST_LED_COUNT, reset_words: RST_RESET_WORDS,
                duty_one: RST_DUTY, duty_zero: RST_DUTY, duty_latch: RST_DUTY,
                global_level: RST_GLOBAL_LEVEL};
    tx_on   = 1'b0;
    tx_pos  = 0;
    n_items = 0;
    steady  = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: idle tick, spare opcode, full and over-full brightness, ignored writes
    load_regs('{chain_leds: 7'd2, reset_words: 8'd1, duty_one: 16'hFFFF,
                duty_zero: 16'h0001, duty_latch: 16'h8000, global_level: LEVEL_FULL});
    send(any_item(OP_TICK));
    send(any_item(OP_SPARE));
    send(colour_item(8'd0, 8'hFF, 8'hFF, 8'hFF, LEVEL_FULL));
    send(colour_item(8'd1, 8'h80, 8'h01, 8'hFF, 9'h1FF));
    send(colour_item(8'd2, 8'hFF, 8'hFF, 8'hFF, 9'd0));
    send(colour_item(8'hFF, 8'hFF, 8'hFF, 8'hFF, LEVEL_FULL));
    // Update, then an update while the frame is going out
    send(any_item(OP_UPDATE));
    send(any_item(OP_UPDATE));
    repeat (3) send(any_item(OP_TICK));
    // Shrink the chain mid-frame: the next word is a reset word and ends the frame
    drain();
    regs.chain_leds = 7'd0;
    load_regs(regs);
    send(any_item(OP_TICK));
    // Empty frame starts nothing
    drain();
    regs.reset_words = 8'd0;
    load_regs(regs);
    send(any_item(OP_UPDATE));
    send(any_item(OP_TICK));
    // Frame of reset words only
    drain();
    regs.reset_words = 8'd2;
    load_regs(regs);
    send(any_item(OP_UPDATE));
    send(any_item(OP_TICK));
    send(any_item(OP_TICK));

    // Random phases
    for (int phase = 0; n_items < ITEM_GOAL; phase++) run_phase(phase);

    drain();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
